// ===== design/pwmps_pkg.sv =====
// ----------------------------------------------------------------------------
// pwmps_pkg
// Shared types, constants and helper functions of the PWM set-point block.
// ----------------------------------------------------------------------------
package pwmps_pkg;

	// field widths
	localparam int FREQ_W     = 16;
	localparam int CODE_W     = 8;
	localparam int PCT_W      = 8;
	localparam int PCT_KEEP_W = 7;
	localparam int TOP_W      = 16;
	localparam int PRESC_W    = 3;
	localparam int CH_N       = 3;
	localparam int CH_IDX_W   = 2;

	// stream words
	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 72;

	// config port
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 16;
	localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_FREQ = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CH0_CODE     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CH1_CODE     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CH2_CODE     = 2'd3;

	// reset values
	localparam logic [FREQ_W-1:0] DEFAULT_FREQ_RST = 16'd1000;
	localparam logic [CODE_W-1:0] CH0_CODE_RST     = 8'd0;
	localparam logic [CODE_W-1:0] CH1_CODE_RST     = 8'd1;
	localparam logic [CODE_W-1:0] CH2_CODE_RST     = 8'd2;
	localparam logic [TOP_W-1:0]  TOP_RST          = 16'd1999;
	localparam logic [TOP_W-1:0]  TOP_MIN          = 16'd99;

	// prescaler bands (lower limits)
	localparam logic [FREQ_W-1:0] BAND_DIV1_LO    = 16'd40001;
	localparam logic [FREQ_W-1:0] BAND_DIV2_LO    = 16'd20001;
	localparam logic [FREQ_W-1:0] BAND_DIV4_LO    = 16'd10001;
	localparam logic [FREQ_W-1:0] BAND_DIV8_LO    = 16'd2001;
	localparam logic [FREQ_W-1:0] BAND_DIV16_LO   = 16'd501;
	localparam logic [FREQ_W-1:0] BAND_DIV256_LO  = 16'd101;
	localparam logic [FREQ_W-1:0] BAND_DIV1024_LO = 16'd1;

	// prescale codes
	localparam logic [PRESC_W-1:0] PRESC_DIV1    = 3'd0;
	localparam logic [PRESC_W-1:0] PRESC_DIV2    = 3'd1;
	localparam logic [PRESC_W-1:0] PRESC_DIV4    = 3'd2;
	localparam logic [PRESC_W-1:0] PRESC_DIV8    = 3'd3;
	localparam logic [PRESC_W-1:0] PRESC_DIV16   = 3'd4;
	localparam logic [PRESC_W-1:0] PRESC_DIV64   = 3'd5;
	localparam logic [PRESC_W-1:0] PRESC_DIV256  = 3'd6;
	localparam logic [PRESC_W-1:0] PRESC_DIV1024 = 3'd7;

	// divider sizing: largest prescale*f*2 over all bands is 256*500*2
	localparam int SHIFT_W      = 4;
	localparam int MAX_SHIFT    = 10;
	localparam int WIDE_W       = FREQ_W + MAX_SHIFT + 1;
	localparam int DEN_W        = 18;
	localparam int MAX_HALF_DEN = 128000;

	// compare arithmetic: percent * (top + 1) + 50 fits 23 bits
	localparam int PROD_W   = 23;
	localparam int MUL_W    = 24;
	localparam int PCT_MAX  = 100;
	localparam int PCT_HALF = 50;

	// divide by 100 as x * ceil(2^30 / 100) >> 30, exact for x below 2^30 / 76
	localparam int                 RECIP_SHIFT = 30;
	localparam int                 RECIP_W     = 24;
	localparam logic [RECIP_W-1:0] RECIP_100   = 24'd10737419;
	localparam int                 RPROD_W     = PROD_W + RECIP_W;
	localparam int                 CMPQ_W      = TOP_W + 1;

	typedef struct packed {
		logic                 valid;
		logic [PRESC_W-1:0]   code;
	} band_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic                 load;
		logic                 init;
		logic                 store_freq;
		logic                 div_period;
		logic                 apply_period;
		logic                 mul;
		logic                 div_cmp;
		logic                 write_cmp;
		logic                 send;
		logic                 duty;
		logic [CH_IDX_W-1:0]  idx;
	} dp_cmd_t;

	// status back to the controller
	typedef struct packed {
		logic kind;
		logic initialized;
		logic freq_eq;
		logic band_valid;
		logic sel_valid;
		logic div_done;
		logic out_free;
	} dp_stat_t;

	function automatic band_t band_of(input logic [FREQ_W-1:0] f);
		band_t b;
		b.valid = 1'b1;
		if (f >= BAND_DIV1_LO)         b.code = PRESC_DIV1;
		else if (f >= BAND_DIV2_LO)    b.code = PRESC_DIV2;
		else if (f >= BAND_DIV4_LO)    b.code = PRESC_DIV4;
		else if (f >= BAND_DIV8_LO)    b.code = PRESC_DIV8;
		else if (f >= BAND_DIV16_LO)   b.code = PRESC_DIV16;
		else if (f >= BAND_DIV256_LO)  b.code = PRESC_DIV256;
		else if (f >= BAND_DIV1024_LO) b.code = PRESC_DIV1024;
		else begin
			b.valid = 1'b0;
			b.code  = PRESC_DIV1;
		end
		return b;
	endfunction

	// log2 of the prescale division
	function automatic logic [SHIFT_W-1:0] presc_shift(input logic [PRESC_W-1:0] code);
		logic [SHIFT_W-1:0] s;
		case (code)
			PRESC_DIV1:    s = 4'd0;
			PRESC_DIV2:    s = 4'd1;
			PRESC_DIV4:    s = 4'd2;
			PRESC_DIV8:    s = 4'd3;
			PRESC_DIV16:   s = 4'd4;
			PRESC_DIV64:   s = 4'd6;
			PRESC_DIV256:  s = 4'd8;
			PRESC_DIV1024: s = 4'd10;
			default:       s = 4'd0;
		endcase
		return s;
	endfunction

endpackage

// ===== design/pwm_period_and_duty_setpoint.sv =====
// ----------------------------------------------------------------------------
// pwm_period_and_duty_setpoint
// Set-point calculator for a three-channel dual-slope PWM timer.
// ----------------------------------------------------------------------------
// usage
//   s_* takes one request word: s_tuser is the kind (0 set frequency, 1 set
//   duty), s_tdata carries frequency, channel code and percent. every request
//   gives exactly one m_* word with the timer state after the update.
//   cfg_we/cfg_index/cfg_data write the default frequency and the three
//   channel codes; write them only while no request is in flight.
// sequencing
//   one request at a time. the serial period divider takes one quotient bit
//   per cycle; each compare divides by 100 through a reciprocal multiply. a
//   frequency change runs the period division and then all three compares,
//   a duty request one compare, a first duty request the period division as
//   well; a repeated or zero frequency skips the arithmetic. the next request
//   is accepted the cycle after the result word is loaded for output.
// reset
//   arst_n clears the timer state to stopped, period 1999, compares and
//   enables zero, and loads the config reset values. no clearing pass.
// back-pressure
//   the result sits in an output register; the next request is accepted
//   while it waits, and that request's result waits for the slot to free.
// ----------------------------------------------------------------------------
module pwm_period_and_duty_setpoint #(
	parameter int CLOCK_HZ = 20000000
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// config write port
	input  logic                                 cfg_we,
	input  logic [pwmps_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pwmps_pkg::CFG_W-1:0]          cfg_data,
	// request stream
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [pwmps_pkg::IN_DATA_W-1:0]      s_tdata,   // frequency, channel, percent
	input  logic                                 s_tuser,   // kind
	// result stream
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// timer_running, prescale_code, period, compare_zero, compare_one,
	// compare_two, output_enables, one zero pad bit
	output logic [pwmps_pkg::OUT_DATA_W-1:0]     m_tdata
);
	import pwmps_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// sequencing of one request
	pwmps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// state, arithmetic and the output register
	pwmps_dp #(
		.CLOCK_HZ (CLOCK_HZ)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (s_tdata),
		.in_kind   (s_tuser),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule

// ===== design/pwmps_div.sv =====
// ----------------------------------------------------------------------------
// pwmps_div
// Serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pwmps_div #(
	parameter int NUM_W = 25,
	parameter int DEN_W = 18
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             busy,
	output logic             done,
	output logic [NUM_W-1:0] quo
);
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic             fits;

	assign trial = {rem_q, num_q[NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], fits};
			rem_q <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = num_q;

endmodule

// ===== design/pwmps_dp.sv =====
// ----------------------------------------------------------------------------
// pwmps_dp
// Datapath: config registers, timer set-point state, period arithmetic around
// a serial divider, compare arithmetic by reciprocal multiply, and the output
// register.
// ----------------------------------------------------------------------------
module pwmps_dp #(
	parameter int CLOCK_HZ = 20000000
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [pwmps_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pwmps_pkg::CFG_W-1:0]          cfg_data,
	input  logic [pwmps_pkg::IN_DATA_W-1:0]      in_data,
	input  logic                                 in_kind,
	input  pwmps_pkg::dp_cmd_t                   cmd,
	output pwmps_pkg::dp_stat_t                  stat,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [pwmps_pkg::OUT_DATA_W-1:0]     out_data
);
	import pwmps_pkg::*;

	localparam int NUM_W = $clog2(CLOCK_HZ + MAX_HALF_DEN + 1);

	// config registers
	logic [FREQ_W-1:0] default_freq_q;
	logic [CODE_W-1:0] ch_code_q [CH_N];

	// request latched at accept
	logic                  kind_q;
	logic [FREQ_W-1:0]     freq_q;
	logic [PCT_KEEP_W-1:0] pct_q;
	logic [CH_IDX_W-1:0]   sel_q;
	logic                  sel_valid_q;

	// timer state
	logic                  initialized_q;
	logic [FREQ_W-1:0]     stored_freq_q;
	logic                  running_q;
	logic [PRESC_W-1:0]    presc_q;
	logic [TOP_W-1:0]      top_q;
	logic [PCT_KEEP_W-1:0] percent_q [CH_N];
	logic [TOP_W-1:0]      compare_q [CH_N];
	logic [CH_N-1:0]       enable_q;

	logic [PROD_W-1:0]     prod_q;
	logic [CMPQ_W-1:0]     cmp_quo_q;
	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	logic [FREQ_W-1:0]     in_freq;
	logic [CODE_W-1:0]     in_ch;
	logic [PCT_W-1:0]      in_pct;
	logic [PCT_KEEP_W-1:0] in_pct_clamped;
	band_t                 band;
	logic [SHIFT_W-1:0]    shift;
	logic [WIDE_W-1:0]     den_wide;
	logic [WIDE_W-1:0]     half_wide;
	logic [NUM_W-1:0]      num_period;
	logic [PROD_W-1:0]     num_cmp;
	logic [RPROD_W-1:0]    recip_prod;
	logic                  div_start;
	logic                  div_busy;
	logic                  div_done;
	logic [NUM_W-1:0]      div_num;
	logic [DEN_W-1:0]      div_den;
	logic [NUM_W-1:0]      quo;
	logic [NUM_W-1:0]      quo_m1;
	logic [TOP_W-1:0]      period_new;
	logic [TOP_W-1:0]      cmp_sat;
	logic [PCT_KEEP_W-1:0] mul_pct;
	logic [MUL_W-1:0]      mul_wide;
	logic                  out_free;

	assign in_freq = in_data[FREQ_W-1:0];
	assign in_ch   = in_data[FREQ_W+CODE_W-1:FREQ_W];
	assign in_pct  = in_data[FREQ_W+CODE_W+PCT_W-1:FREQ_W+CODE_W];
	assign in_pct_clamped = (in_pct > PCT_W'(PCT_MAX)) ? PCT_KEEP_W'(PCT_MAX)
		: in_pct[PCT_KEEP_W-1:0];

	// period: round(CLOCK_HZ / (prescale * f * 2)), the shift gives the prescale
	assign band       = band_of(freq_q);
	assign shift      = presc_shift(band.code);
	assign den_wide   = WIDE_W'(freq_q) << (shift + SHIFT_W'(1));
	assign half_wide  = WIDE_W'(freq_q) << shift;
	assign num_period = NUM_W'(CLOCK_HZ) + NUM_W'(half_wide[DEN_W-1:0]);

	// compare: rounded divide by 100 through the reciprocal
	assign num_cmp    = prod_q + PROD_W'(PCT_HALF);
	assign recip_prod = RPROD_W'(num_cmp) * RPROD_W'(RECIP_100);

	assign div_start = cmd.div_period;
	assign div_num   = num_period;
	assign div_den   = den_wide[DEN_W-1:0];

	pwmps_div #(
		.NUM_W (NUM_W),
		.DEN_W (DEN_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.done   (div_done),
		.quo    (quo)
	);

	// rounded quotient minus one, clamped to the legal top range
	assign quo_m1 = quo - NUM_W'(1);
	always_comb begin
		if (|quo_m1[NUM_W-1:TOP_W])
			period_new = '1;
		else if (quo_m1[TOP_W-1:0] < TOP_MIN)
			period_new = TOP_MIN;
		else
			period_new = quo_m1[TOP_W-1:0];
	end

	assign cmp_sat  = cmp_quo_q[TOP_W] ? '1 : cmp_quo_q[TOP_W-1:0];
	assign mul_pct  = cmd.duty ? pct_q : percent_q[cmd.idx];
	assign mul_wide = MUL_W'(mul_pct) * (MUL_W'(top_q) + MUL_W'(1));

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_freq_q <= DEFAULT_FREQ_RST;
			ch_code_q[0]   <= CH0_CODE_RST;
			ch_code_q[1]   <= CH1_CODE_RST;
			ch_code_q[2]   <= CH2_CODE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEFAULT_FREQ: default_freq_q <= cfg_data[FREQ_W-1:0];
				REG_CH0_CODE:     ch_code_q[0]   <= cfg_data[CODE_W-1:0];
				REG_CH1_CODE:     ch_code_q[1]   <= cfg_data[CODE_W-1:0];
				REG_CH2_CODE:     ch_code_q[2]   <= cfg_data[CODE_W-1:0];
				default: ;
			endcase
		end
	end

	// request capture; a duty request works on the default frequency if it
	// has to initialise the timer
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= in_kind;
			freq_q <= in_kind ? default_freq_q : in_freq;
			pct_q  <= in_pct_clamped;
			if (in_ch == ch_code_q[0]) begin
				sel_q       <= 2'd0;
				sel_valid_q <= 1'b1;
			end else if (in_ch == ch_code_q[1]) begin
				sel_q       <= 2'd1;
				sel_valid_q <= 1'b1;
			end else if (in_ch == ch_code_q[2]) begin
				sel_q       <= 2'd2;
				sel_valid_q <= 1'b1;
			end else begin
				sel_q       <= 2'd0;
				sel_valid_q <= 1'b0;
			end
		end
		if (cmd.mul)
			prod_q <= mul_wide[PROD_W-1:0];
		if (cmd.div_cmp)
			cmp_quo_q <= recip_prod[RECIP_SHIFT+CMPQ_W-1:RECIP_SHIFT];
		if (cmd.send)
			out_data_q <= {1'b0, enable_q, compare_q[2], compare_q[1], compare_q[0],
				top_q, presc_q, running_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			initialized_q <= 1'b0;
			stored_freq_q <= '0;
			running_q     <= 1'b0;
			presc_q       <= PRESC_DIV1;
			top_q         <= TOP_RST;
			enable_q      <= '0;
			out_valid_q   <= 1'b0;
			for (int k = 0; k < CH_N; k++) begin
				percent_q[k] <= '0;
				compare_q[k] <= '0;
			end
		end else begin
			if (cmd.init) begin
				initialized_q <= 1'b1;
				stored_freq_q <= freq_q;
				running_q     <= 1'b0;
				presc_q       <= PRESC_DIV1;
				top_q         <= TOP_RST;
				enable_q      <= '0;
				for (int k = 0; k < CH_N; k++)
					compare_q[k] <= '0;
			end
			if (cmd.store_freq)
				stored_freq_q <= freq_q;
			// a zero rounded quotient leaves the timer as it is
			if (cmd.apply_period && (quo != '0)) begin
				top_q     <= period_new;
				presc_q   <= band.code;
				running_q <= 1'b1;
			end
			if (cmd.write_cmp) begin
				if (cmd.duty) begin
					compare_q[sel_q] <= cmp_sat;
					percent_q[sel_q] <= pct_q;
					enable_q[sel_q]  <= 1'b1;
				end else begin
					compare_q[cmd.idx] <= cmp_sat;
				end
			end
			if (cmd.send)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		stat.kind        = kind_q;
		stat.initialized = initialized_q;
		stat.freq_eq     = stored_freq_q == freq_q;
		stat.band_valid  = band.valid;
		stat.sel_valid   = sel_valid_q;
		stat.div_done    = div_done;
		stat.out_free    = out_free;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// the timer never sits below the minimum top
	a_top_min: assert property (@(posedge clk) disable iff (!arst_n)
		top_q >= TOP_MIN)
		else $error("top below minimum");

	// the div64 band is never chosen while running
	a_no_div64: assert property (@(posedge clk) disable iff (!arst_n)
		running_q |-> presc_q != PRESC_DIV64)
		else $error("div64 prescaler selected");

	// nothing runs or drives before the first request
	a_uninit: assert property (@(posedge clk) disable iff (!arst_n)
		!initialized_q |-> (!running_q && enable_q == '0))
		else $error("timer active before initialisation");

	// a new word is only loaded into a free output slot
	a_send_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.send |-> out_free)
		else $error("output overwritten");

	// the divider is only started when idle
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider restarted while busy");

endmodule

// ===== design/pwmps_ctrl.sv =====
// ----------------------------------------------------------------------------
// pwmps_ctrl
// Controller state machine: sequences initialisation, period division and
// compare recomputation for one request at a time.
// ----------------------------------------------------------------------------
module pwmps_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  pwmps_pkg::dp_stat_t  stat,
	output pwmps_pkg::dp_cmd_t   cmd
);
	import pwmps_pkg::*;

	localparam int ST_W = 4;
	localparam logic [ST_W-1:0] S_IDLE   = 4'd0;
	localparam logic [ST_W-1:0] S_DECIDE = 4'd1;
	localparam logic [ST_W-1:0] S_PDIV   = 4'd2;
	localparam logic [ST_W-1:0] S_PWAIT  = 4'd3;
	localparam logic [ST_W-1:0] S_DUTY   = 4'd4;
	localparam logic [ST_W-1:0] S_CMUL   = 4'd5;
	localparam logic [ST_W-1:0] S_CDIV   = 4'd6;
	localparam logic [ST_W-1:0] S_CWAIT  = 4'd7;
	localparam logic [ST_W-1:0] S_DONE   = 4'd8;

	localparam logic [CH_IDX_W-1:0] LAST_CH = CH_IDX_W'(CH_N - 1);

	logic [ST_W-1:0]     state_q, state_n;
	logic                rec_q, rec_n;
	logic                duty_q, duty_n;
	logic [CH_IDX_W-1:0] idx_q, idx_n;

	always_comb begin
		state_n = state_q;
		rec_n   = rec_q;
		duty_n  = duty_q;
		idx_n   = idx_q;
		cmd     = '0;
		cmd.duty = duty_q;
		cmd.idx  = idx_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					rec_n    = 1'b0;
					duty_n   = 1'b0;
					idx_n    = '0;
					state_n  = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (!stat.initialized) begin
					cmd.init = 1'b1;
					if (stat.band_valid)
						state_n = S_PDIV;
					else
						state_n = stat.kind ? S_DUTY : S_DONE;
				end else if (!stat.kind) begin
					if (stat.freq_eq) begin
						state_n = S_DONE;
					end else begin
						cmd.store_freq = 1'b1;
						rec_n   = 1'b1;
						state_n = stat.band_valid ? S_PDIV : S_DONE;
					end
				end else begin
					state_n = S_DUTY;
				end
			end
			S_PDIV: begin
				cmd.div_period = 1'b1;
				state_n = S_PWAIT;
			end
			S_PWAIT: begin
				if (stat.div_done) begin
					cmd.apply_period = 1'b1;
					if (rec_q)
						state_n = S_CMUL;
					else
						state_n = stat.kind ? S_DUTY : S_DONE;
				end
			end
			S_DUTY: begin
				if (stat.sel_valid) begin
					duty_n  = 1'b1;
					state_n = S_CMUL;
				end else begin
					state_n = S_DONE;
				end
			end
			S_CMUL: begin
				cmd.mul = 1'b1;
				state_n = S_CDIV;
			end
			S_CDIV: begin
				cmd.div_cmp = 1'b1;
				state_n = S_CWAIT;
			end
			// compare quotient is registered, write it back
			S_CWAIT: begin
				cmd.write_cmp = 1'b1;
				if (duty_q || idx_q == LAST_CH) begin
					state_n = S_DONE;
				end else begin
					idx_n   = idx_q + CH_IDX_W'(1);
					state_n = S_CMUL;
				end
			end
			S_DONE: begin
				if (stat.out_free) begin
					cmd.send = 1'b1;
					state_n  = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rec_q   <= 1'b0;
			duty_q  <= 1'b0;
			idx_q   <= '0;
		end else begin
			state_q <= state_n;
			rec_q   <= rec_n;
			duty_q  <= duty_n;
			idx_q   <= idx_n;
		end
	end

	assign in_ready = state_q == S_IDLE;

endmodule

// ===== sim/pwm_period_and_duty_setpoint_test.sv =====
// ----------------------------------------------------------------------------
// pwm_period_and_duty_setpoint_test
// Self-checking bench for the PWM set-point calculator. Request words go in on
// the slave stream with random gaps. A behavioral copy of the timer set-point
// state predicts every timer word that a directed row does not type in; the
// master stream is itself stalled at random. Directed rows cover the band edges, the first-request
// initialisation and the duty corner cases. Random phases follow, each with
// its own channel codes and default frequency.
// ----------------------------------------------------------------------------
module pwm_period_and_duty_setpoint_test;
	timeunit 1ns;
	timeprecision 1ps;

	import pwmps_pkg::*;

	localparam int unsigned CLK_HZ     = 20000000;
	localparam int unsigned LIMIT      = 1000000;  // cycles before the run is called hung
	localparam int          PHASE_REQS = 213;      // random requests per phase
	localparam int          SETTLE     = 200;      // cycles after the last word

	typedef enum logic {
		SET_FREQ = 1'b0,
		SET_DUTY = 1'b1
	} request_kind_t;

	// one timer word, msb first: pad, enables, compare 2..0, period, prescale, running
	typedef struct packed {
		logic                pad;
		logic [CH_N-1:0]     enables;
		logic [TOP_W-1:0]    cmp2;
		logic [TOP_W-1:0]    cmp1;
		logic [TOP_W-1:0]    cmp0;
		logic [TOP_W-1:0]    period;
		logic [PRESC_W-1:0]  presc;
		logic                running;
	} timer_word_t;

	// directed request, with the timer word typed in where it is obvious
	typedef struct packed {
		request_kind_t       kind;
		logic [FREQ_W-1:0]   freq;
		logic [CODE_W-1:0]   ch;
		logic [PCT_W-1:0]    pct;
		logic                typed;
		timer_word_t         want;
	} dir_row_t;

	localparam timer_word_t NONE = '0;

	// frequencies on either side of every band limit
	localparam logic [FREQ_W-1:0] FREQ_EDGES [15] = '{
		16'd0, 16'd1, 16'd100, 16'd101, 16'd500, 16'd501, 16'd2000, 16'd2001,
		16'd10000, 16'd10001, 16'd20000, 16'd20001, 16'd40000, 16'd40001, 16'd65535
	};

	// the default frequency is 0 and the codes are 0, 1, 2 when these run
	dir_row_t directed_rows [25] = '{
		// duty before any frequency: initialises at 0 Hz, timer stays stopped
		{SET_DUTY, 16'd0, 8'd0, 8'd255, 1'b1,
			{1'b0, 3'b001, 16'd0, 16'd0, 16'd2000, 16'd1999, PRESC_DIV1, 1'b0}},
		// unknown channel code changes nothing
		{SET_DUTY, 16'd0, 8'd200, 8'd0, 1'b1,
			{1'b0, 3'b001, 16'd0, 16'd0, 16'd2000, 16'd1999, PRESC_DIV1, 1'b0}},
		// same frequency as stored
		{SET_FREQ, 16'd0, 8'd0, 8'd0, 1'b1,
			{1'b0, 3'b001, 16'd0, 16'd0, 16'd2000, 16'd1999, PRESC_DIV1, 1'b0}},
		{SET_DUTY, 16'd0, 8'd1, 8'd50, 1'b1,
			{1'b0, 3'b011, 16'd0, 16'd1000, 16'd2000, 16'd1999, PRESC_DIV1, 1'b0}},
		{SET_DUTY, 16'd0, 8'd2, 8'd100, 1'b1,
			{1'b0, 3'b111, 16'd2000, 16'd1000, 16'd2000, 16'd1999, PRESC_DIV1, 1'b0}},
		{SET_FREQ, 16'd65535, 8'd0, 8'd0, 1'b0, NONE},
		{SET_FREQ, 16'd65535, 8'd0, 8'd0, 1'b0, NONE},
		{SET_FREQ, 16'd40001, 8'd0, 8'd0, 1'b0, NONE},
		{SET_FREQ, 16'd40000, 8'd0, 8'd0, 1'b0, NONE},
		{SET_FREQ, 16'd20001, 8'd0, 8'd0, 1'b0, NONE},
		{SET_FREQ, 16'd20000, 8'd0, 8'd0, 1'b0, NONE},
		{SET_FREQ, 16'd10001, 8'd0, 8'd0, 1'b0, NONE},
		{SET_FREQ, 16'd10000, 8'd0, 8'd0, 1'b0, NONE},
		{SET_FREQ, 16'd2001, 8'd0, 8'd0, 1'b0, NONE},
		{SET_FREQ, 16'd2000, 8'd0, 8'd0, 1'b0, NONE},
		{SET_FREQ, 16'd501, 8'd0, 8'd0, 1'b0, NONE},
		{SET_FREQ, 16'd500, 8'd0, 8'd0, 1'b0, NONE},   // period clamps up to 99
		{SET_FREQ, 16'd101, 8'd0, 8'd0, 1'b0, NONE},
		{SET_FREQ, 16'd100, 8'd0, 8'd0, 1'b0, NONE},
		{SET_FREQ, 16'd1, 8'd0, 8'd0, 1'b0, NONE},
		// zero once running: only the stored frequency moves
		{SET_FREQ, 16'd0, 8'd0, 8'd0, 1'b0, NONE},
		{SET_FREQ, 16'd1, 8'd0, 8'd0, 1'b0, NONE},
		{SET_DUTY, 16'd0, 8'd0, 8'd0, 1'b0, NONE},
		{SET_DUTY, 16'd0, 8'd1, 8'd101, 1'b0, NONE},   // clamps to 100
		{SET_DUTY, 16'd0, 8'd2, 8'd99, 1'b0, NONE}
	};

	// dut ports
	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_W-1:0]      cfg_data = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;    // frequency, channel, percent
	logic                  s_tuser = 1'b0;  // kind
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;         // running, prescale, period, compares, enables, pad

	// timer set-point state as the bench sees it
	logic                  tm_init;
	logic [FREQ_W-1:0]     tm_freq;
	logic                  tm_run;
	logic [PRESC_W-1:0]    tm_presc;
	logic [TOP_W-1:0]      tm_top;
	logic [PCT_KEEP_W-1:0] tm_pct [CH_N];
	logic [TOP_W-1:0]      tm_cmp [CH_N];
	logic [CH_N-1:0]       tm_en;
	logic [FREQ_W-1:0]     tm_default_freq;
	logic [CODE_W-1:0]     tm_code [CH_N];

	timer_word_t           timer_words_due [$];
	timer_word_t           seen_word;
	timer_word_t           due_word;
	int unsigned           mismatches = 0;
	int unsigned           cycles = 0;
	logic                  rx_quiet = 1'b0;
	int unsigned           rx_hold = 0;

	pwm_period_and_duty_setpoint #(
		.CLOCK_HZ(CLK_HZ)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// set-point arithmetic
	// ------------------------------------------------------------------------

	// prescaler band of a frequency; returns 0 when there is none (0 Hz)
	function automatic bit band_for(input logic [FREQ_W-1:0] f,
			output logic [PRESC_W-1:0] code);
		code = PRESC_DIV1;
		if (f >= BAND_DIV1_LO) code = PRESC_DIV1;
		else if (f >= BAND_DIV2_LO) code = PRESC_DIV2;
		else if (f >= BAND_DIV4_LO) code = PRESC_DIV4;
		else if (f >= BAND_DIV8_LO) code = PRESC_DIV8;
		else if (f >= BAND_DIV16_LO) code = PRESC_DIV16;
		else if (f >= BAND_DIV256_LO) code = PRESC_DIV256;
		else if (f >= BAND_DIV1024_LO) code = PRESC_DIV1024;
		else return 1'b0;
		return 1'b1;
	endfunction

	function automatic longint unsigned presc_ratio(input logic [PRESC_W-1:0] code);
		case (code)
			PRESC_DIV1:    return 1;
			PRESC_DIV2:    return 2;
			PRESC_DIV4:    return 4;
			PRESC_DIV8:    return 8;
			PRESC_DIV16:   return 16;
			PRESC_DIV64:   return 64;
			PRESC_DIV256:  return 256;
			default:       return 1024;
		endcase
	endfunction

	// rounded clock / (prescale * f * 2) - 1, clamped; 0 when the quotient rounds to 0
	function automatic longint unsigned period_from(input logic [FREQ_W-1:0] f,
			input logic [PRESC_W-1:0] code);
		longint unsigned den;
		longint unsigned q;
		den = presc_ratio(code) * longint'(f) * 2;
		if (den == 0) return 0;
		q = (longint'(CLK_HZ) + den / 2) / den;
		if (q == 0) return 0;
		q = q - 1;
		if (q < 99) q = 99;
		if (q > 65535) q = 65535;
		return q;
	endfunction

	// compare for a duty against the current top, saturated to 16 bits
	function automatic logic [TOP_W-1:0] compare_from(input logic [PCT_W-1:0] pct);
		longint unsigned p;
		longint unsigned c;
		p = (pct > 8'd100) ? 100 : pct;
		c = (p * (longint'(tm_top) + 1) + 50) / 100;
		return (c > 65535) ? 16'hFFFF : c[TOP_W-1:0];
	endfunction

	function automatic void take_band(input logic [FREQ_W-1:0] f,
			input logic [PRESC_W-1:0] code);
		longint unsigned per;
		per = period_from(f, code);
		if (per != 0) begin
			tm_top = per[TOP_W-1:0];
			tm_presc = code;
			tm_run = 1'b1;
		end
	endfunction

	// frequency request, including the one-time timer start
	function automatic void retune(input logic [FREQ_W-1:0] f);
		logic [PRESC_W-1:0] code;
		bit ok;
		ok = band_for(f, code);
		if (!tm_init) begin
			tm_run = 1'b0;
			tm_presc = PRESC_DIV1;
			tm_top = TOP_RST;
			tm_en = '0;
			for (int k = 0; k < CH_N; k++) tm_cmp[k] = '0;
			if (ok) take_band(f, code);
			tm_freq = f;
			tm_init = 1'b1;
		end else if (tm_freq != f) begin
			// zero keeps the old period and compares, only the stored value moves
			if (ok) begin
				take_band(f, code);
				for (int k = 0; k < CH_N; k++) tm_cmp[k] = compare_from({1'b0, tm_pct[k]});
			end
			tm_freq = f;
		end
	endfunction

	// applies one request to the state and gives the timer word it should produce
	function automatic timer_word_t timer_after_request(input request_kind_t kind,
			input logic [FREQ_W-1:0] f, input logic [CODE_W-1:0] ch,
			input logic [PCT_W-1:0] pct);
		timer_word_t w;
		logic [PCT_W-1:0] duty;
		int sel;
		sel = -1;
		duty = (pct > 8'd100) ? 8'd100 : pct;
		if (kind == SET_FREQ) begin
			retune(f);
		end else begin
			if (!tm_init) retune(tm_default_freq);
			// lowest channel wins when codes collide
			if (ch == tm_code[0]) sel = 0;
			else if (ch == tm_code[1]) sel = 1;
			else if (ch == tm_code[2]) sel = 2;
			if (sel >= 0) begin
				tm_cmp[sel] = compare_from(duty);
				tm_pct[sel] = duty[PCT_KEEP_W-1:0];
				tm_en[sel] = 1'b1;
			end
		end
		w = '0;
		w.running = tm_run;
		w.presc = tm_presc;
		w.period = tm_top;
		w.cmp0 = tm_cmp[0];
		w.cmp1 = tm_cmp[1];
		w.cmp2 = tm_cmp[2];
		w.enables = tm_en;
		return w;
	endfunction

	// ------------------------------------------------------------------------
	// stimulus side
	// ------------------------------------------------------------------------

	// drives one request word, waits for the handshake and books its timer word
	task automatic push_request(input request_kind_t kind, input logic [FREQ_W-1:0] f,
			input logic [CODE_W-1:0] ch, input logic [PCT_W-1:0] pct,
			input bit may_idle, input bit typed, input timer_word_t typed_word);
		int gap;
		timer_word_t predicted;
		if (may_idle && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 8);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {pct, ch, f};
		do @(posedge clk); while (!s_tready);
		predicted = timer_after_request(kind, f, ch, pct);
		timer_words_due.push_back(typed ? typed_word : predicted);
	endtask

	// sender holds off until every booked timer word has come back
	task automatic wait_until_caught_up();
		s_tvalid <= 1'b0;
		while (timer_words_due.size() != 0) @(posedge clk);
	endtask

	// register write; write enable stays high so back-to-back writes need no toggle
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			REG_DEFAULT_FREQ: tm_default_freq = data;
			REG_CH0_CODE:     tm_code[0] = data[CODE_W-1:0];
			REG_CH1_CODE:     tm_code[1] = data[CODE_W-1:0];
			REG_CH2_CODE:     tm_code[2] = data[CODE_W-1:0];
			default:          ;
		endcase
	endtask

	// new setting, only once the block is idle
	task automatic configure(input logic [CFG_W-1:0] dflt, input logic [CFG_W-1:0] c0,
			input logic [CFG_W-1:0] c1, input logic [CFG_W-1:0] c2);
		wait_until_caught_up();
		repeat (8) @(posedge clk);
		write_register(REG_DEFAULT_FREQ, dflt);
		write_register(REG_CH0_CODE, c0);
		write_register(REG_CH1_CODE, c1);
		write_register(REG_CH2_CODE, c2);
		cfg_we <= 1'b0;
	endtask

	// mostly duty requests on live codes, frequencies spread over the bands
	task automatic run_random_phase(input int count, input bit calm);
		request_kind_t kind;
		logic [FREQ_W-1:0] f;
		logic [CODE_W-1:0] ch;
		logic [PCT_W-1:0] pct;
		for (int i = 0; i < count; i++) begin
			kind = ($urandom_range(0, 9) < 6) ? SET_DUTY : SET_FREQ;
			case ($urandom_range(0, 7))
				0:       f = tm_freq;                            // repeat of the stored value
				1:       f = FREQ_EDGES[$urandom_range(0, 14)];
				2:       f = '0;
				3, 4:    f = FREQ_W'($urandom_range(1, 2000));
				default: f = FREQ_W'($urandom_range(0, 65535));
			endcase
			if ($urandom_range(0, 4) != 0) ch = tm_code[$urandom_range(0, CH_N - 1)];
			else ch = CODE_W'($urandom_range(0, 255));
			case ($urandom_range(0, 9))
				0:       pct = PCT_W'($urandom_range(101, 255));
				1:       pct = ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd100;
				2:       pct = '0;
				default: pct = PCT_W'($urandom_range(0, 100));
			endcase
			// first 30 of every 100 requests go back to back
			push_request(kind, f, ch, pct, !calm && (i % 100) >= 30, 1'b0, NONE);
			if (!calm && $urandom_range(0, 63) == 0) wait_until_caught_up();
		end
	endtask

	// ------------------------------------------------------------------------
	// result side
	// ------------------------------------------------------------------------

	task automatic report_mismatch(input string what, input longint unsigned got,
			input longint unsigned want);
		if (mismatches < 40)
			$display("mismatch at cycle %0d: %s got %0d want %0d", cycles, what, got, want);
		mismatches++;
	endtask

	// receiver stalls in bursts, with calm stretches while cycle counter bits 9:8 are zero
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_hold <= 0;
		end else if (rx_hold != 0) begin
			rx_hold <= rx_hold - 1;
		end else if (!rx_quiet && cycles[9:8] != 2'b00 && $urandom_range(0, 5) == 0) begin
			m_tready <= 1'b0;
			rx_hold <= $urandom_range(0, 7);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// every accepted timer word against the oldest booked one
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (timer_words_due.size() == 0) begin
				report_mismatch("timer word with none booked", m_tdata[63:0], 0);
			end else begin
				seen_word = m_tdata;
				due_word = timer_words_due.pop_front();
				if (seen_word.running !== due_word.running)
					report_mismatch("timer_running", seen_word.running, due_word.running);
				if (seen_word.presc !== due_word.presc)
					report_mismatch("prescale_code", seen_word.presc, due_word.presc);
				if (seen_word.period !== due_word.period)
					report_mismatch("period", seen_word.period, due_word.period);
				if (seen_word.cmp0 !== due_word.cmp0)
					report_mismatch("compare_zero", seen_word.cmp0, due_word.cmp0);
				if (seen_word.cmp1 !== due_word.cmp1)
					report_mismatch("compare_one", seen_word.cmp1, due_word.cmp1);
				if (seen_word.cmp2 !== due_word.cmp2)
					report_mismatch("compare_two", seen_word.cmp2, due_word.cmp2);
				if (seen_word.enables !== due_word.enables)
					report_mismatch("output_enables", seen_word.enables, due_word.enables);
				if (seen_word.pad !== 1'b0)
					report_mismatch("pad bit", seen_word.pad, 0);
			end
		end
	end

	// hang guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// run
	// ------------------------------------------------------------------------

	initial begin
		// bench state matches the block after reset
		tm_init = 1'b0;
		tm_freq = '0;
		tm_run = 1'b0;
		tm_presc = PRESC_DIV1;
		tm_top = TOP_RST;
		tm_en = '0;
		for (int k = 0; k < CH_N; k++) begin
			tm_pct[k] = '0;
			tm_cmp[k] = '0;
		end
		tm_default_freq = DEFAULT_FREQ_RST;
		tm_code[0] = CH0_CODE_RST;
		tm_code[1] = CH1_CODE_RST;
		tm_code[2] = CH2_CODE_RST;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero default so the first duty starts a stopped timer; upper code bits are dropped
		configure(16'd0, 16'hA500, 16'hFF01, 16'h0002);
		foreach (directed_rows[r])
			push_request(directed_rows[r].kind, directed_rows[r].freq, directed_rows[r].ch,
				directed_rows[r].pct, 1'b1, directed_rows[r].typed, directed_rows[r].want);
		run_random_phase(PHASE_REQS, 1'b0);

		// colliding codes at the top of the range, default at its maximum
		configure(16'hFFFF, 16'h00FF, 16'hFFFF, 16'h0000);
		run_random_phase(PHASE_REQS, 1'b0);

		for (int p = 0; p < 3; p++) begin
			configure(CFG_W'($urandom_range(0, 65535)), CFG_W'($urandom_range(0, 65535)),
				CFG_W'($urandom_range(0, 65535)), CFG_W'($urandom_range(0, 65535)));
			run_random_phase(PHASE_REQS, 1'b0);
		end

		// closing phase at full rate on both sides
		configure(DEFAULT_FREQ_RST, 16'd0, 16'd1, 16'd2);
		rx_quiet <= 1'b1;
		run_random_phase(PHASE_REQS, 1'b1);

		s_tvalid <= 1'b0;
		while (timer_words_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
design/pwmps_pkg.sv
design/pwmps_div.sv
design/pwmps_dp.sv
design/pwmps_ctrl.sv
design/pwm_period_and_duty_setpoint.sv
sim/pwm_period_and_duty_setpoint_test.sv
